@@ design/matrix_keypad_debounce_scanner_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Keypad scanner assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_DEBOUNCE_SCANNER_UNIT_MACROS_SVH
`define MATRIX_KEYPAD_DEBOUNCE_SCANNER_UNIT_MACROS_SVH

// same-cycle implication
`define KPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/kpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Keypad scanner package
// Shared types, register codes, reset values and the key character table.
// ----------------------------------------------------------------------------
package kpd_pkg;

    localparam int COL_W    = 4;
    localparam int ROW_W    = 4;
    localparam int CHAR_W   = 8;
    localparam int DEB_W    = 24;
    localparam int SETTLE_W = 16;
    localparam int ROWIDX_W = 3;
    localparam int COLIDX_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 2'd1;

    localparam logic [DEB_W-1:0]    DEBOUNCE_RESET = 24'd79999;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET   = 16'd160;

    localparam logic [CHAR_W-1:0] KEY_LUT [4][4] = '{
        '{"1", "2", "3", "A"},
        '{"4", "5", "6", "B"},
        '{"7", "8", "9", "C"},
        '{"E", "0", "F", "D"}
    };

    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_DEBOUNCE = 3'b010,
        PH_SCAN     = 3'b100
    } t_kpd_phase;

    typedef struct packed {
        logic [ROW_W-1:0]  row_drive;
        logic [CHAR_W-1:0] key_char;
        logic              key_ready;
        logic              busy_res;
    } t_kpd_result;

endpackage

@@ design/kpd_if.sv @@
// ----------------------------------------------------------------------------
// Keypad scanner channel interfaces
// Pin sample input, per-tick result output and register write channel.
// ----------------------------------------------------------------------------
interface kpd_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] col_levels;
    logic       read_key;

    modport source (output valid, output col_levels, output read_key, input ready);
    modport sink   (input valid, input col_levels, input read_key, output ready);
endinterface

interface kpd_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_drive;
    logic [7:0] key_char;
    logic       key_ready;
    logic       busy_res;

    modport source (output valid, output row_drive, output key_char, output key_ready,
                    output busy_res, input ready);
    modport sink   (input valid, input row_drive, input key_char, input key_ready,
                    input busy_res, output ready);
endinterface

interface kpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/kpd_scan_core.sv @@
// ----------------------------------------------------------------------------
// Keypad scan core
// Edge detect, debounce wait, row-by-row scan and key store; one tick per
// accepted sample.
// ----------------------------------------------------------------------------
`include "matrix_keypad_debounce_scanner_unit_macros.svh"

module kpd_scan_core #(
    parameter int ROW_COUNT    = 4,
    parameter int COLUMN_COUNT = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [kpd_pkg::COL_W-1:0]     i_col_levels,
    input  logic                          i_read_key,
    input  logic [kpd_pkg::DEB_W-1:0]     i_debounce_ticks,
    input  logic [kpd_pkg::SETTLE_W-1:0]  i_settle_ticks,
    output kpd_pkg::t_kpd_result          o_result
);
    import kpd_pkg::*;

    localparam logic [COL_W-1:0] COL_MASK =
        (COLUMN_COUNT >= COL_W) ? {COL_W{1'b1}} : COL_W'((1 << COLUMN_COUNT) - 1);
    localparam logic [ROWIDX_W:0] ROW_LIMIT = (ROWIDX_W + 1)'(ROW_COUNT);

    logic [COL_W-1:0]    r_prev_cols,   n_prev_cols;
    t_kpd_phase          r_phase,       n_phase;
    logic [COLIDX_W-1:0] r_latched_col, n_latched_col;
    logic [DEB_W-1:0]    r_wait,        n_wait;
    logic [ROWIDX_W-1:0] r_scan_row,    n_scan_row;
    logic [CHAR_W-1:0]   r_stored_key,  n_stored_key;
    logic                r_ready_flag,  n_ready_flag;

    logic [COL_W-1:0]    edges;
    logic [ROWIDX_W:0]   row_inc;
    logic [7:0]          row_onehot;
    logic [CHAR_W-1:0]   key_char;
    logic                busy;
    logic [ROW_W-1:0]    drive;

    always_comb begin
        n_prev_cols   = i_col_levels;
        n_phase       = r_phase;
        n_latched_col = r_latched_col;
        n_wait        = r_wait;
        n_scan_row    = r_scan_row;
        n_stored_key  = r_stored_key;
        n_ready_flag  = r_ready_flag;
        key_char      = '0;
        busy          = 1'b0;
        drive         = '0;
        edges         = (i_col_levels ^ r_prev_cols) & COL_MASK;
        row_inc       = {1'b0, r_scan_row} + 1'b1;
        row_onehot    = 8'd1 << r_scan_row;

        // read is served from the state at the start of the tick
        if (i_read_key) begin
            key_char     = r_ready_flag ? r_stored_key : '0;
            n_ready_flag = 1'b0;
            n_stored_key = '0;
        end

        case (r_phase)
            PH_DEBOUNCE: begin
                busy = 1'b1;
                if (r_wait >= i_debounce_ticks) begin
                    n_phase    = PH_SCAN;
                    n_scan_row = '0;
                    n_wait     = '0;
                end else begin
                    n_wait = r_wait + 1'b1;
                end
            end
            PH_SCAN: begin
                busy  = 1'b1;
                drive = ~row_onehot[ROW_W-1:0];
                if (r_wait >= {{(DEB_W-SETTLE_W){1'b0}}, i_settle_ticks}) begin
                    n_wait = '0;
                    if (!i_col_levels[r_latched_col]) begin
                        if (!r_scan_row[ROWIDX_W-1]) begin
                            n_stored_key = KEY_LUT[r_scan_row[1:0]][r_latched_col];
                            n_ready_flag = 1'b1;
                        end
                        n_phase    = PH_IDLE;
                        n_scan_row = '0;
                    end else if (row_inc >= ROW_LIMIT) begin
                        n_phase    = PH_IDLE;
                        n_scan_row = '0;
                    end else begin
                        n_scan_row = row_inc[ROWIDX_W-1:0];
                    end
                end else begin
                    n_wait = r_wait + 1'b1;
                end
            end
            default: begin
                // idle; lowest changed column wins
                n_phase = PH_IDLE;
                if (edges != '0) begin
                    if (edges[0])      n_latched_col = 2'd0;
                    else if (edges[1]) n_latched_col = 2'd1;
                    else if (edges[2]) n_latched_col = 2'd2;
                    else               n_latched_col = 2'd3;
                    n_phase = PH_DEBOUNCE;
                    n_wait  = '0;
                end
            end
        endcase
    end

    always_comb begin
        o_result.row_drive = drive;
        o_result.key_char  = key_char;
        o_result.key_ready = n_ready_flag;
        o_result.busy_res  = busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_cols   <= '1;
            r_phase       <= PH_IDLE;
            r_latched_col <= '0;
            r_wait        <= '0;
            r_scan_row    <= '0;
            r_stored_key  <= '0;
            r_ready_flag  <= 1'b0;
        end else if (i_accept) begin
            r_prev_cols   <= n_prev_cols;
            r_phase       <= n_phase;
            r_latched_col <= n_latched_col;
            r_wait        <= n_wait;
            r_scan_row    <= n_scan_row;
            r_stored_key  <= n_stored_key;
            r_ready_flag  <= n_ready_flag;
        end
    end

    `KPD_ASSERT_SAME(a_scan_row_in_range, r_phase == PH_SCAN,
        {1'b0, r_scan_row} < ROW_LIMIT, "scan row beyond row count")
    `KPD_ASSERT_SAME(a_busy_when_active, i_accept && r_phase != PH_IDLE,
        o_result.busy_res, "busy low while debouncing or scanning")
    `KPD_ASSERT_NEXT(a_read_clears_idle, i_accept && i_read_key && r_phase == PH_IDLE,
        !r_ready_flag, "ready flag survived a read while idle")
    `KPD_ASSERT_SAME(a_ready_has_key, r_ready_flag,
        r_stored_key != '0, "ready flag set with empty key")

endmodule

@@ design/matrix_keypad_debounce_scanner_unit.sv @@
// Results are registered: each is presented in the cycle after its sample is accepted.
// Throughput: one sample per cycle while o_out.ready is high; the result register frees each cycle it is taken.
// Debounce and scan progress count accepted samples, not raw clocks.
// Reset (synchronous, active low): idle, columns seen as all high, no key stored,
// registers back to 79999 debounce and 160 settle ticks.
// ----------------------------------------------------------------------------
// Matrix keypad debounce scanner
// Top level: register file, scan core and the output result register.
// ----------------------------------------------------------------------------
module matrix_keypad_debounce_scanner_unit #(
    parameter int ROW_COUNT    = 4,
    parameter int COLUMN_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kpd_in_if.sink      i_in,
    kpd_out_if.source   o_out,
    kpd_cfg_if.sink     i_cfg
);
    import kpd_pkg::*;

    logic [DEB_W-1:0]    r_debounce_ticks;
    logic [SETTLE_W-1:0] r_settle_ticks;
    logic                r_out_valid;
    t_kpd_result         r_out;
    t_kpd_result         core_result;
    logic                in_accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= DEBOUNCE_RESET;
            r_settle_ticks   <= SETTLE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DEBOUNCE: r_debounce_ticks <= i_cfg.data;
                REG_SETTLE:   r_settle_ticks   <= i_cfg.data[SETTLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    kpd_scan_core #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_col_levels     (i_in.col_levels),
        .i_read_key       (i_in.read_key),
        .i_debounce_ticks (r_debounce_ticks),
        .i_settle_ticks   (r_settle_ticks),
        .o_result         (core_result)
    );

    // result register: refills in the same cycle its transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= core_result;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.row_drive = r_out.row_drive;
    assign o_out.key_char  = r_out.key_char;
    assign o_out.key_ready = r_out.key_ready;
    assign o_out.busy_res  = r_out.busy_res;

endmodule
